// ----- hw/rtl/hash_keyed_table_triangular_probe_macros.svh -----
// Assertion macros shared by the hash table RTL modules.
`ifndef HASH_KEYED_TABLE_TRIANGULAR_PROBE_MACROS_SVH
`define HASH_KEYED_TABLE_TRIANGULAR_PROBE_MACROS_SVH

// Check a consequence in the same cycle; uses the module's clock and reset.
`define HKTP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the next cycle.
`define HKTP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/hktp_pkg.sv -----
// Shared types, codes and constants of the triangular-probe hash table.
package hktp_pkg;

   localparam int SLOTS_DEFAULT = 128;
   localparam int KEY_W         = 32;
   localparam int DATA_W        = 32;
   localparam int STATUS_W      = 3;
   localparam int SLOT_W        = 7;

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_ADD    = 1'b1;

   localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
   localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd5;

   typedef struct packed {
      logic              operation;
      logic [KEY_W-1:0]  key_hash;
      logic [DATA_W-1:0] entry_data;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0]   data_out;
      logic [SLOT_W-1:0]   slot_index;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic clear_en;
      logic load;
      logic hash_step;
      logic bucket_load;
      logic bucket_adv;
      logic finish;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic clear_done;
      logic hash_done;
      logic key_zero;
      logic hit;
      logic empty;
      logic last_step;
      logic out_free;
   } stat_type;

endpackage

// ----- hw/rtl/hktp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module hktp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/hktp_ctrl.sv -----
// Controller state machine: clearing pass, hashing, probe loop and result handoff.
`include "hash_keyed_table_triangular_probe_macros.svh"

module hktp_ctrl import hktp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_HASH  = 5'b00100,
      S_READ  = 5'b01000,
      S_CHECK = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (stat.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (stat.key_zero) begin
               // zero key: report once the output word is free, no probe
               if (stat.out_free) begin
                  cmd.finish = 1'b1;
                  state_in   = S_IDLE;
               end
            end else begin
               cmd.hash_step = 1'b1;
               if (stat.hash_done) begin
                  cmd.bucket_load = 1'b1;
                  state_in        = S_READ;
               end
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (stat.hit || stat.empty || stat.last_step) begin
               // hold here until the output word is free
               if (stat.out_free) begin
                  cmd.finish = 1'b1;
                  state_in   = S_IDLE;
               end
            end else begin
               cmd.bucket_adv = 1'b1;
               state_in       = S_READ;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   `HKTP_ASSERT_NEXT(a_accept_hash, req_valid && req_ready, state_ff == S_HASH, "accept must start hashing")
   `HKTP_ASSERT_NOW(a_finish_free, cmd.finish, stat.out_free, "result finished into a busy output word")
   `HKTP_ASSERT_NOW(a_adv_in_range, cmd.bucket_adv, !stat.last_step, "probe advanced past the last step")

endmodule

// ----- hw/rtl/hktp_dp.sv -----
// Datapath: home slot reduction, probe bucket and step, key and data stores, result word.
`include "hash_keyed_table_triangular_probe_macros.svh"

module hktp_dp import hktp_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   input  cmd_type  cmd,
   output stat_type stat,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   localparam int             IW        = $clog2(SLOTS);
   localparam logic [IW:0]    SlotsW    = (IW+1)'(SLOTS);
   localparam logic [IW-1:0]  LastIdx   = IW'(SLOTS - 1);
   localparam bit             SlotsPow2 = ((SLOTS & (SLOTS - 1)) == 0);

   logic              op_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [DATA_W-1:0] entry_ff;

   logic [IW-1:0] bucket_ff, bucket_in;
   logic [IW-1:0] step_ff, step_in;
   logic [IW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [IW:0]   adv_sum;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic [IW-1:0]     home;
   logic              hash_done;
   logic [KEY_W-1:0]  held_key;
   logic [DATA_W-1:0] held_data;
   logic              ins_we;
   logic              key_we;
   logic [IW-1:0]     key_wr_addr;
   logic [KEY_W-1:0]  key_wr_data;

   // Latch the request word on accept.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_data.operation;
         key_ff   <= req_data.key_hash;
         entry_ff <= req_data.entry_data;
      end
   end

   // Home slot: key modulo SLOTS.
   generate
      if (SlotsPow2) begin : g_mask
         assign home      = key_ff[IW-1:0];
         assign hash_done = 1'b1;
      end else begin : g_recip
         localparam logic [KEY_W-1:0] Recip = KEY_W'((64'd1 << KEY_W) / 64'(SLOTS));

         logic [2*KEY_W-1:0] prod_full;
         logic [IW:0]        quot_ff, quot_in;
         logic [IW-1:0]      rem_ff, rem_in;
         logic [1:0]         ph_ff, ph_in;
         logic [IW:0]        rem_x;

         // Estimate the quotient by a reciprocal; it is at most one low, so fix once.
         always_comb begin
            prod_full = (2*KEY_W)'(key_ff) * (2*KEY_W)'(Recip);
            rem_x     = key_ff[IW:0] - quot_ff * SlotsW;
            if (rem_x >= SlotsW) begin
               rem_x = rem_x - SlotsW;
            end
            quot_in = quot_ff;
            rem_in  = rem_ff;
            ph_in   = ph_ff;
            if (cmd.load) begin
               ph_in = '0;
            end else if (cmd.hash_step && !ph_ff[1]) begin
               if (ph_ff == 2'd0) begin
                  quot_in = prod_full[KEY_W +: IW+1];
               end else begin
                  rem_in = rem_x[IW-1:0];
               end
               ph_in = ph_ff + 2'd1;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               quot_ff <= '0;
               rem_ff  <= '0;
               ph_ff   <= '0;
            end else begin
               quot_ff <= quot_in;
               rem_ff  <= rem_in;
               ph_ff   <= ph_in;
            end
         end

         assign home      = rem_ff;
         assign hash_done = ph_ff[1];
      end
   endgenerate

   // Triangular step: bucket + step + 1, wrapped once.
   always_comb begin
      adv_sum = {1'b0, bucket_ff} + {1'b0, step_ff} + (IW+1)'(1);
      if (adv_sum >= SlotsW) begin
         adv_sum = adv_sum - SlotsW;
      end
      bucket_in = bucket_ff;
      step_in   = step_ff;
      if (cmd.bucket_load) begin
         bucket_in = home;
         step_in   = '0;
      end else if (cmd.bucket_adv) begin
         bucket_in = adv_sum[IW-1:0];
         step_in   = step_ff + IW'(1);
      end
   end

   always_comb begin
      clr_cnt_in = cmd.clear_en ? clr_cnt_ff + IW'(1) : clr_cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_ff  <= '0;
         step_ff    <= '0;
         clr_cnt_ff <= '0;
      end else begin
         bucket_ff  <= bucket_in;
         step_ff    <= step_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // Status toward the controller.
   always_comb begin
      stat.clear_done = (clr_cnt_ff == LastIdx);
      stat.hash_done  = hash_done;
      stat.key_zero   = (key_ff == '0);
      stat.hit        = (held_key == key_ff);
      stat.empty      = (held_key == '0);
      stat.last_step  = (step_ff == LastIdx);
      stat.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign ins_we      = cmd.finish && !stat.key_zero && !stat.hit && stat.empty
                        && (op_ff == OP_ADD);
   assign key_we      = cmd.clear_en || ins_we;
   assign key_wr_addr = cmd.clear_en ? clr_cnt_ff : bucket_ff;
   assign key_wr_data = cmd.clear_en ? '0 : key_ff;

   hktp_ram #(
      .WIDTH(KEY_W),
      .DEPTH(SLOTS)
   ) u_key_ram (
      .clock  (clock),
      .wr_en  (key_we),
      .wr_addr(key_wr_addr),
      .wr_data(key_wr_data),
      .rd_addr(bucket_ff),
      .rd_data(held_key)
   );

   hktp_ram #(
      .WIDTH(DATA_W),
      .DEPTH(SLOTS)
   ) u_data_ram (
      .clock  (clock),
      .wr_en  (ins_we),
      .wr_addr(bucket_ff),
      .wr_data(entry_ff),
      .rd_addr(bucket_ff),
      .rd_data(held_data)
   );

   // Result word.
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         if (stat.key_zero) begin
            rsp_in.status     = ST_INVALID;
            rsp_in.data_out   = '0;
            rsp_in.slot_index = '0;
         end else if (stat.hit) begin
            rsp_in.status     = (op_ff == OP_ADD) ? ST_PRESENT : ST_FOUND;
            rsp_in.data_out   = held_data;
            rsp_in.slot_index = SLOT_W'(bucket_ff);
         end else if (stat.empty) begin
            rsp_in.status     = (op_ff == OP_ADD) ? ST_INSERTED : ST_NOT_FOUND;
            rsp_in.data_out   = '0;
            rsp_in.slot_index = SLOT_W'(bucket_ff);
         end else begin
            rsp_in.status     = ST_FULL;
            rsp_in.data_out   = '0;
            rsp_in.slot_index = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `HKTP_ASSERT_NOW(a_no_insert_clear, ins_we, !cmd.clear_en, "insert during clearing pass")
   `HKTP_ASSERT_NEXT(a_zero_invalid, cmd.finish && stat.key_zero, rsp_valid && rsp_data.status == ST_INVALID, "zero key not flagged")
   `HKTP_ASSERT_NEXT(a_hit_data, cmd.finish && !stat.key_zero && stat.hit, rsp_data.data_out == $past(held_data), "hit lost stored handle")

endmodule

// ----- hw/rtl/hash_keyed_table_triangular_probe.sv -----
// Each item: accept in S_IDLE, home-slot reduction in S_HASH (a mask for power-of-two SLOTS,
// a reciprocal quotient estimate and one correction otherwise), then probes, each a key RAM
// read (S_READ) and a compare (S_CHECK), up to SLOTS probes on a full table. One item at a
// time: no new request is accepted until the result of the last one is handed off.
// Reset: synchronous; afterwards a clearing pass zeroes every key RAM slot, during which
// req_ready stays low.
module hash_keyed_table_triangular_probe import hktp_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   hktp_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   hktp_dp #(
      .SLOTS(SLOTS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

endmodule
